FILE: design/m1553_pkg.sv
// Shared constants and types for the 1553 word Manchester encoder.
// No dependencies; imported by every module of the block.
package m1553_pkg;

    localparam logic [1:0] SYM_H = 2'b01;
    localparam logic [1:0] SYM_L = 2'b10;

    localparam int FRAME_SYMBOLS = 40;
    localparam int SYMS_PER_WORD = 16;
    localparam int FRAME_WORDS   = 3;
    localparam int FRAME_BITS    = 2 * FRAME_SYMBOLS;
    localparam int OUT_BITS      = 2 * SYMS_PER_WORD;
    localparam int DATA_BITS     = 16;

    localparam logic [1:0] WORD_FIRST = 2'd0;
    localparam logic [1:0] WORD_FINAL = 2'(FRAME_WORDS - 1);

    localparam logic SYNC_CMD  = 1'b0;
    localparam logic SYNC_DATA = 1'b1;

    // Encoded frame handed from the encode stage to the serializer
    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] frame;
    } t_frame;

endpackage

FILE: design/m1553_enc.sv
// Encode stage: sync, Manchester II data pairs and odd parity into a 40-symbol frame.
// Depends on m1553_pkg.
module m1553_enc
    import m1553_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_sync_kind,
    input  logic [DATA_BITS-1:0] i_data_word,
    output t_frame               o_frame
);

    logic [FRAME_BITS-1:0] n_frame;
    logic [FRAME_BITS-1:0] r_frame;
    logic                  r_valid;
    logic                  parity;

    // Set when the word holds an even number of ones
    assign parity = ~^i_data_word;

    always_comb begin
        n_frame = '0;
        for (int s = 0; s < 3; s++) begin
            n_frame[2*s +: 2]     = (i_sync_kind == SYNC_CMD) ? SYM_H : SYM_L;
            n_frame[2*s + 6 +: 2] = (i_sync_kind == SYNC_CMD) ? SYM_L : SYM_H;
        end
        // Data MSB first, two symbols per bit
        for (int i = 0; i < DATA_BITS; i++) begin
            n_frame[12 + 4*i +: 4] = i_data_word[DATA_BITS-1-i] ? {SYM_L, SYM_H}
                                                                : {SYM_H, SYM_L};
        end
        n_frame[FRAME_BITS-4 +: 4] = parity ? {SYM_L, SYM_H} : {SYM_H, SYM_L};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_frame <= n_frame;
        end
    end

    assign o_frame = '{valid: r_valid, frame: r_frame};

endmodule

FILE: design/m1553_ser.sv
// Serializer and output register: splits a frame into three 32-bit words.
// Depends on m1553_pkg.
module m1553_ser
    import m1553_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_frame              i_frame,
    output logic                o_strobe,
    output logic [OUT_BITS-1:0] o_symbol_word,
    output logic [1:0]          o_word_number,
    output logic                o_last_word
);

    localparam int REST_BITS = FRAME_BITS - OUT_BITS;

    logic                 r_strobe, n_strobe;
    logic [OUT_BITS-1:0]  r_out, n_out;
    logic [1:0]           r_num, n_num;
    logic [REST_BITS-1:0] r_rest, n_rest;

    always_comb begin
        n_strobe = 1'b0;
        n_out    = r_out;
        n_num    = r_num;
        n_rest   = r_rest;
        if (i_frame.valid) begin
            n_strobe = 1'b1;
            n_out    = i_frame.frame[OUT_BITS-1:0];
            n_num    = WORD_FIRST;
            n_rest   = i_frame.frame[FRAME_BITS-1:OUT_BITS];
        end else if (r_strobe && r_num != WORD_FINAL) begin
            // Advance to the next word; the last one gets zero upper bits
            n_strobe = 1'b1;
            n_out    = r_rest[OUT_BITS-1:0];
            n_num    = r_num + 2'd1;
            n_rest   = {{OUT_BITS{1'b0}}, r_rest[REST_BITS-1:OUT_BITS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_num    <= WORD_FIRST;
        end else begin
            r_strobe <= n_strobe;
            r_num    <= n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_rest <= n_rest;
    end

    assign o_strobe      = r_strobe;
    assign o_symbol_word = r_out;
    assign o_word_number = r_num;
    assign o_last_word   = (r_num == WORD_FINAL);

endmodule

FILE: design/mil1553_word_manchester_encoder.sv
// Top level of the 1553 word Manchester encoder: input stage and admission control.
// Depends on m1553_pkg, m1553_enc and m1553_ser.
//
// A word is taken when start is high and busy is low. The first of its three
// 32-bit symbol words then appears on the outputs with o_strobe, followed by the
// second and third on consecutive cycles, with no gaps; the receiver cannot hold
// results off, so they must be taken as they come. The output channel sends one
// symbol word per cycle, so a new input word waits until the serializer can take
// it: busy stays high after each accepted word until the hold counter is zero.
// The path is the input register, encode register and serializer output register.
module mil1553_word_manchester_encoder
    import m1553_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_sync_kind,
    input  logic [DATA_BITS-1:0] i_data_word,
    output logic                 o_strobe,
    output logic [OUT_BITS-1:0]  o_symbol_word,
    output logic [1:0]           o_word_number,
    output logic                 o_last_word
);

    logic                 accept;
    logic                 r_valid;
    logic                 r_sync_kind;
    logic [DATA_BITS-1:0] r_data_word;
    logic [1:0]           r_hold, n_hold;
    t_frame               frame;

    assign accept = start && !busy;
    assign busy   = (r_hold != 2'd0);

    // Hold off new items until the serializer has room
    always_comb begin
        n_hold = r_hold;
        if (accept) begin
            n_hold = 2'(FRAME_WORDS - 1);
        end else if (r_hold != 2'd0) begin
            n_hold = r_hold - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_hold  <= n_hold;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sync_kind <= i_sync_kind;
            r_data_word <= i_data_word;
        end
    end

    m1553_enc u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_valid),
        .i_sync_kind (r_sync_kind),
        .i_data_word (r_data_word),
        .o_frame     (frame)
    );

    m1553_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (frame),
        .o_strobe      (o_strobe),
        .o_symbol_word (o_symbol_word),
        .o_word_number (o_word_number),
        .o_last_word   (o_last_word)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted item");

    a_accept_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 (o_strobe && o_word_number == WORD_FIRST))
        else $error("first word did not appear three cycles after accept");

    a_word_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_word) |=> (o_strobe && o_word_number == $past(o_word_number) + 2'd1))
        else $error("frame words not contiguous");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frame.valid && o_strobe) |-> o_last_word)
        else $error("new frame arrived while a frame was still being sent");

    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_word) |-> (o_symbol_word[OUT_BITS-1:FRAME_BITS-2*OUT_BITS] == '0))
        else $error("upper bits of the final word not zero");

endmodule
